>>> hdl/suse_pkg.sv
// Shared types and codes for the sorted unique set engine.
package suse_pkg;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_DELETE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  localparam int CountFieldWidth = 7;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the request
    logic compare;  // register per-cell compare flags
    logic update;   // shift cells, update count, load result
  } cmd_t;

endpackage

>>> hdl/suse_if.sv
// Valid/ready channel interfaces for requests and responses.
interface suse_req_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface suse_rsp_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                                      valid;
  logic                                      ready;
  logic [2:0]                                status;
  logic [suse_pkg::CountFieldWidth-1:0]      element_count;
  logic signed [VALUE_WIDTH-1:0]             first_value;
  logic                                      is_empty;

  modport source (output valid, output status, output element_count,
                  output first_value, output is_empty, input ready);
  modport sink   (input valid, input status, input element_count,
                  input first_value, input is_empty, output ready);
endinterface

>>> hdl/sorted_unique_set_engine.sv
// Top level of the sorted unique set engine.
//
// Keeps up to CAPACITY distinct signed values in sorted order in a row of
// register cells. Each request on "req" carries func (insert or delete) and
// a value; each request yields exactly one response on "rsp" with a status,
// the element count, the head value (zero when empty) and an empty flag.
// cfg_we/cfg_wdata set the order: 0 ascending from the head, 1 descending.
// Write it only while no request is in flight.
//
// Steps: a request accepted in the load step is compared against every cell
// in parallel in the compare step; in the update step the cells shift and
// the response register loads, raising rsp.valid. The next request can be
// accepted in that same update step, but not during the compare step; the
// request pace is set by the compare stage and then the shift of the cell row.
// If rsp is stalled, the response stays registered and the engine holds in
// its update step until the response register drains.
// Reset (rst, synchronous) empties the set and selects ascending order;
// cell contents are not cleared and are never read beyond the count.
module sorted_unique_set_engine #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        cfg_wdata,
  suse_req_if.sink   req,
  suse_rsp_if.source rsp
);

  suse_pkg::cmd_t cmd;

  // Sequencer: owns handshakes and the step order.
  suse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Cell row, count, order bit and response register.
  suse_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .req_func      (req.func),
    .req_value     (req.value),
    .status        (rsp.status),
    .element_count (rsp.element_count),
    .first_value   (rsp.first_value),
    .is_empty      (rsp.is_empty)
  );

  // A request never enters during the compare step.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted during compare step");

  // An empty set reports a zero head value.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |-> (rsp.first_value == '0))
    else $error("empty set with nonzero head value");

  // Empty flag agrees with the count (while the count field can hold it).
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((CAPACITY > 127) ||
                   (rsp.is_empty == (rsp.element_count == '0))))
    else $error("empty flag and count disagree");

  // A full rejection only happens with the set at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == suse_pkg::ST_FULL)) |->
      (rsp.element_count == suse_pkg::CountFieldWidth'(CAPACITY)))
    else $error("store full reported below capacity");

endmodule

>>> hdl/suse_ctrl.sv
// Sequencer for the sorted set: load, compare, update with output handshake.
module suse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output suse_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_emit;

  // result register free, or being drained this cycle
  assign can_emit  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) || ((state == S_UPD) && can_emit);

  always_comb begin
    cmd.load    = req_valid && req_ready;
    cmd.compare = (state == S_CMP);
    cmd.update  = (state == S_UPD) && can_emit;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (can_emit) state_next = cmd.load ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/suse_dp.sv
// Datapath: row of sorted value cells with per-cell compare and shift.
module suse_dp #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  input  suse_pkg::cmd_t                       cmd,
  input  logic                                 req_func,
  input  logic signed [VALUE_WIDTH-1:0]        req_value,
  output logic [2:0]                           status,
  output logic [suse_pkg::CountFieldWidth-1:0] element_count,
  output logic signed [VALUE_WIDTH-1:0]        first_value,
  output logic                                 is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                          order_desc;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  suse_pkg::func_t               op;
  logic signed [VALUE_WIDTH-1:0] val;
  logic signed [VALUE_WIDTH-1:0] cells      [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cells_next [CAPACITY];
  logic [CAPACITY-1:0]           ahead;
  logic [CAPACITY-1:0]           ahead_next;
  logic [CAPACITY-1:0]           match;
  logic [CAPACITY-1:0]           match_next;
  logic                          found;
  logic                          full;
  logic                          do_ins;
  logic                          do_del;
  suse_pkg::status_t             status_next;

  // Per-cell compare and shift. "ahead" flags form a prefix of the row,
  // so the first clear flag marks the ordered position of the value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                          in_use;
    logic                          at_pos;
    logic signed [VALUE_WIDTH-1:0] from_below;
    logic signed [VALUE_WIDTH-1:0] from_above;

    assign in_use        = count > CW'(i);
    assign ahead_next[i] = in_use &&
                           (order_desc ? (cells[i] > val) : (cells[i] < val));
    assign match_next[i] = in_use && (cells[i] == val);

    if (i == 0) begin : g_head
      assign at_pos     = 1'b1;
      assign from_below = val;
    end else begin : g_body
      assign at_pos     = ahead[i-1];
      assign from_below = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign from_above = cells[i];
    end else begin : g_inner
      assign from_above = cells[i+1];
    end

    always_comb begin
      if (do_ins && !ahead[i]) begin
        cells_next[i] = at_pos ? val : from_below;
      end else if (do_del && !ahead[i]) begin
        cells_next[i] = from_above;
      end else begin
        cells_next[i] = cells[i];
      end
    end
  end

  assign found = |match;
  assign full  = (count == CW'(CAPACITY));

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    count_next  = count;
    status_next = suse_pkg::ST_ABSENT;
    if (op == suse_pkg::FN_INSERT) begin
      if (found) begin
        status_next = suse_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_next = suse_pkg::ST_FULL;
      end else begin
        do_ins      = 1'b1;
        count_next  = count + 1'b1;
        status_next = suse_pkg::ST_INSERTED;
      end
    end else if (found) begin
      do_del      = 1'b1;
      count_next  = count - 1'b1;
      status_next = suse_pkg::ST_REMOVED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_desc <= 1'b0;
      count      <= '0;
    end else begin
      if (cfg_we) order_desc <= cfg_wdata;
      if (cmd.update) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= suse_pkg::func_t'(req_func);
      val <= req_value;
    end
    if (cmd.compare) begin
      ahead <= ahead_next;
      match <= match_next;
    end
    if (cmd.update) begin
      cells         <= cells_next;
      status        <= status_next;
      element_count <= suse_pkg::CountFieldWidth'(count_next);
      first_value   <= (count_next != '0) ? cells_next[0] : '0;
      is_empty      <= (count_next == '0);
    end
  end

endmodule
